### rtl/alle_pkg.sv
// Shared definitions for the array linked list engine: status codes, field
// widths and the control group that the sequencer sends to the node store.
// No dependencies.
`timescale 1ns / 1ps

package alle_pkg;

   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_SUCC   = 3'd4;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   // Read and write strobes of the node store for one cycle.
   typedef struct packed {
      logic rd_en;
      logic wr_value_en;
      logic wr_link_en;
   } mem_ctl_type;

endpackage

### rtl/alle_node_store.sv
// Node store of the array linked list engine: value and link memories that
// share one read address (registered read) and one write address.
// Depends on alle_pkg.
`timescale 1ns / 1ps

module alle_node_store #(
   parameter int LIST_CAPACITY = 64
) (
   input  logic                                 clock,
   input  alle_pkg::mem_ctl_type                mem_ctl,
   input  logic [$clog2(LIST_CAPACITY)-1:0]     rd_addr,
   input  logic [$clog2(LIST_CAPACITY)-1:0]     wr_addr,
   input  logic [alle_pkg::DATA_W-1:0]          wr_value,
   input  logic [$clog2(LIST_CAPACITY+1)-1:0]   wr_link,
   output logic [alle_pkg::DATA_W-1:0]          rd_value,
   output logic [$clog2(LIST_CAPACITY+1)-1:0]   rd_link
);

   localparam int LinkW = $clog2(LIST_CAPACITY + 1);

   logic [alle_pkg::DATA_W-1:0] node_value_ff [LIST_CAPACITY];
   logic [LinkW-1:0]            node_link_ff  [LIST_CAPACITY];
   logic [alle_pkg::DATA_W-1:0] rd_value_ff;
   logic [LinkW-1:0]            rd_link_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_value_en) begin
         node_value_ff[wr_addr] <= wr_value;
      end
      if (mem_ctl.wr_link_en) begin
         node_link_ff[wr_addr] <= wr_link;
      end
      if (mem_ctl.rd_en) begin
         rd_value_ff <= node_value_ff[rd_addr];
         rd_link_ff  <= node_link_ff[rd_addr];
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_link  = rd_link_ff;

endmodule

### rtl/array_linked_list_engine_top.sv
// Array linked list engine, top level: operation sequencer, list pointers and
// the result register around the node store.
// Depends on alle_pkg and alle_node_store.
`timescale 1ns / 1ps

// A singly linked list kept in a store of LIST_CAPACITY nodes, with a free
// chain of unused slots. Each request beat inserts a value or deletes a node,
// either at the list head or after the first node whose value equals
// req_position_key, and yields exactly one response beat with a status, the
// removed value (zero unless a delete succeeds) and the list length after the
// operation. The engine handles one request at a time and drops req_ready
// while it works. A keyed operation walks the list and visits each node
// with one read of the node store, whose read port is registered, and one
// compare of the stored value with the key. The response sits in an
// output register, so it may wait for rsp_ready without blocking the
// sequencer until the next result is ready. No clearing pass follows reset:
// a high-water mark tracks which slots have ever been allocated, and the link
// of a slot at or above it is taken to hold the next slot index.
module array_linked_list_engine_top #(
   parameter int LIST_CAPACITY = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic                                 req_at_head,
   input  logic signed [31:0]                   req_position_key,
   input  logic signed [31:0]                   req_new_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic signed [31:0]                   rsp_removed_value,
   output logic [$clog2(LIST_CAPACITY+1)-1:0]   rsp_list_length
);

   localparam int IdxW  = $clog2(LIST_CAPACITY);
   localparam int LinkW = $clog2(LIST_CAPACITY + 1);
   localparam logic [LinkW-1:0] NullLink = LinkW'(LIST_CAPACITY);
   localparam logic [LinkW-1:0] LinkOne  = LinkW'(1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECIDE   = 4'd1;
   localparam logic [3:0] S_WALK_RD  = 4'd2;
   localparam logic [3:0] S_WALK_CHK = 4'd3;
   localparam logic [3:0] S_FREE     = 4'd4;
   localparam logic [3:0] S_FREE_CHK = 4'd5;
   localparam logic [3:0] S_INS_WR   = 4'd6;
   localparam logic [3:0] S_INS_LNK  = 4'd7;
   localparam logic [3:0] S_DEL_RD   = 4'd8;
   localparam logic [3:0] S_DEL_CHK  = 4'd9;
   localparam logic [3:0] S_DEL_FREE = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0]                          state_ff, state_in;

   // Latched request.
   logic                                func_ff, at_head_ff;
   logic [alle_pkg::DATA_W-1:0]         key_ff, val_ff;

   // List bookkeeping.
   logic [LinkW-1:0]                    head_ff, head_in;
   logic [LinkW-1:0]                    free_ff, free_in;
   logic [LinkW-1:0]                    count_ff, count_in;
   logic [LinkW-1:0]                    hwm_ff, hwm_in;

   // Working registers of one operation.
   logic [LinkW-1:0]                    ptr_ff, ptr_in;
   logic [LinkW-1:0]                    steps_ff, steps_in;
   logic [IdxW-1:0]                     mtch_ff, mtch_in;
   logic [LinkW-1:0]                    mlink_ff, mlink_in;
   logic [IdxW-1:0]                     slot_ff, slot_in;
   logic [LinkW-1:0]                    nxt_ff, nxt_in;
   logic [alle_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [alle_pkg::DATA_W-1:0]         removed_ff, removed_in;

   // Result register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [alle_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [alle_pkg::DATA_W-1:0]         rsp_removed_value_ff;
   logic [LinkW-1:0]                    rsp_list_length_ff;
   logic                                rsp_load;

   // Node store port.
   alle_pkg::mem_ctl_type               mem_ctl;
   logic [IdxW-1:0]                     rd_addr, wr_addr;
   logic [alle_pkg::DATA_W-1:0]         wr_value, rd_value;
   logic [LinkW-1:0]                    wr_link, rd_link;

   logic                                req_take;
   logic                                key_hit;

   alle_node_store #(
      .LIST_CAPACITY (LIST_CAPACITY)
   ) u_store (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_link  (wr_link),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;

   // The one compare unit: stored value against the search key.
   assign key_hit = (rd_value == key_ff);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      hwm_in     = hwm_ff;
      ptr_in     = ptr_ff;
      steps_in   = steps_ff;
      mtch_in    = mtch_ff;
      mlink_in   = mlink_ff;
      slot_in    = slot_ff;
      nxt_in     = nxt_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      rsp_load   = 1'b0;
      mem_ctl    = '0;
      rd_addr    = ptr_ff[IdxW-1:0];
      wr_addr    = slot_ff;
      wr_value   = val_ff;
      wr_link    = free_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in  = alle_pkg::ST_OK;
               removed_in = '0;
               state_in   = S_DECIDE;
            end
         end

         S_DECIDE: begin
            ptr_in   = head_ff;
            steps_in = '0;
            if (func_ff == alle_pkg::FUNC_INSERT) begin
               if (count_ff >= NullLink || free_ff >= NullLink) begin
                  status_in = alle_pkg::ST_FULL;
                  state_in  = S_DONE;
               end else if (at_head_ff) begin
                  state_in = S_FREE;
               end else begin
                  state_in = S_WALK_RD;
               end
            end else begin
               if (count_ff == '0 || head_ff >= NullLink) begin
                  status_in = alle_pkg::ST_EMPTY;
                  state_in  = S_DONE;
               end else if (at_head_ff) begin
                  slot_in  = head_ff[IdxW-1:0];
                  state_in = S_DEL_RD;
               end else begin
                  state_in = S_WALK_RD;
               end
            end
         end

         // The walk ends with not found at a null link or after LIST_CAPACITY steps.
         S_WALK_RD: begin
            if (ptr_ff >= NullLink || steps_ff == NullLink) begin
               status_in = alle_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = ptr_ff[IdxW-1:0];
               state_in      = S_WALK_CHK;
            end
         end

         S_WALK_CHK: begin
            if (key_hit) begin
               mtch_in  = ptr_ff[IdxW-1:0];
               mlink_in = rd_link;
               if (func_ff == alle_pkg::FUNC_INSERT) begin
                  state_in = S_FREE;
               end else if (rd_link >= NullLink) begin
                  status_in = alle_pkg::ST_NO_SUCC;
                  state_in  = S_DONE;
               end else begin
                  slot_in  = rd_link[IdxW-1:0];
                  state_in = S_DEL_RD;
               end
            end else begin
               ptr_in   = rd_link;
               steps_in = steps_ff + LinkOne;
               state_in = S_WALK_RD;
            end
         end

         // Take the free head. A slot at or above the high-water mark was
         // never allocated, so its link still holds the next slot index.
         S_FREE: begin
            slot_in = free_ff[IdxW-1:0];
            if (free_ff >= hwm_ff) begin
               nxt_in   = free_ff + LinkOne;
               hwm_in   = hwm_ff + LinkOne;
               state_in = S_INS_WR;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = free_ff[IdxW-1:0];
               state_in      = S_FREE_CHK;
            end
         end

         S_FREE_CHK: begin
            nxt_in   = rd_link;
            state_in = S_INS_WR;
         end

         S_INS_WR: begin
            mem_ctl.wr_value_en = 1'b1;
            mem_ctl.wr_link_en  = 1'b1;
            wr_addr             = slot_ff;
            wr_value            = val_ff;
            wr_link             = at_head_ff ? head_ff : mlink_ff;
            free_in             = nxt_ff;
            count_in            = count_ff + LinkOne;
            if (at_head_ff) begin
               head_in  = LinkW'(slot_ff);
               state_in = S_DONE;
            end else begin
               state_in = S_INS_LNK;
            end
         end

         S_INS_LNK: begin
            mem_ctl.wr_link_en = 1'b1;
            wr_addr            = mtch_ff;
            wr_link            = LinkW'(slot_ff);
            state_in           = S_DONE;
         end

         S_DEL_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = slot_ff;
            state_in      = S_DEL_CHK;
         end

         // Unlink the victim: either the head moves on, or the matched node
         // now links past it.
         S_DEL_CHK: begin
            removed_in = rd_value;
            if (at_head_ff) begin
               head_in = rd_link;
            end else begin
               mem_ctl.wr_link_en = 1'b1;
               wr_addr            = mtch_ff;
               wr_link            = rd_link;
            end
            state_in = S_DEL_FREE;
         end

         S_DEL_FREE: begin
            mem_ctl.wr_link_en = 1'b1;
            wr_addr            = slot_ff;
            wr_link            = free_ff;
            free_in            = LinkW'(slot_ff);
            count_in           = count_ff - LinkOne;
            state_in           = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NullLink;
         free_ff      <= '0;
         count_ff     <= '0;
         hwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff    <= req_func;
         at_head_ff <= req_at_head;
         key_ff     <= req_position_key;
         val_ff     <= req_new_value;
      end
      ptr_ff     <= ptr_in;
      steps_ff   <= steps_in;
      mtch_ff    <= mtch_in;
      mlink_ff   <= mlink_in;
      slot_ff    <= slot_in;
      nxt_ff     <= nxt_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (rsp_load) begin
         rsp_status_ff        <= status_ff;
         rsp_removed_value_ff <= removed_ff;
         rsp_list_length_ff   <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_value_ff;
   assign rsp_list_length   = rsp_list_length_ff;

endmodule
